// ===== hdl/sum_checked_frame_receiver_macros.svh =====
// Assertion macros used by the frame receiver top level.
`ifndef SUM_CHECKED_FRAME_RECEIVER_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SCFR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SCFR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/scfr_pkg.sv =====
// Shared types and constants of the checksummed frame receiver.
package scfr_pkg;

  localparam int unsigned KEPT_BYTES = 7;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 32;

  localparam logic [7:0] HEADER_RST = 8'hAA;
  localparam logic [5:0] LIMIT_RST  = 6'd40;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [1:0] REG_LENGTH_LIMIT  = 2'd2;

  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [5:0] length_limit;
  } scfr_cfg_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [5:0]  payload_length;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [7:0]  target_color;
    logic [7:0]  target_shape;
    logic [7:0]  target_flag;
  } scfr_result_t;

endpackage

// ===== hdl/sum_checked_frame_receiver.sv =====
// Top level of the checksummed frame receiver: input register, parser, registers.
//
// Received bytes arrive on rx_byte_i with in_valid_i; a byte is transferred at
// a clock edge where in_valid_i is high and in_stall_o is low. Each frame is
// two header bytes, a length byte below length_limit, the payload and an 8-bit
// additive checksum. The checksum byte yields one result on out_valid_o with
// the verdict, the length and the held target fields; other bytes yield none.
// The byte sits in the input register after its transfer edge and the parser
// step then loads the result register, which raises out_valid_o for the
// checksum byte. Throughput: one byte per cycle unless out_stall_i holds a
// result, set by the single parser step between the two registers.
// When out_stall_i holds a result, the result and its fields stay put; the
// input register takes at most one further byte and in_stall_o is then high
// until the result is transferred.
// Reset sets both headers to 0xAA and the limit to 40, returns the parser to
// hunting and clears the field buffer and the held targets; no result is
// pending after reset. Registers sit at byte addresses 0, 4 and 8; the user
// must write them only while the block is idle; the block does not enforce it.
`include "sum_checked_frame_receiver_macros.svh"

module sum_checked_frame_receiver
  import scfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              checksum_ok_o,
  output logic [5:0]        payload_length_o,
  output logic [15:0]       target_x_o,
  output logic [15:0]       target_y_o,
  output logic [7:0]        target_color_o,
  output logic [7:0]        target_shape_o,
  output logic [7:0]        target_flag_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  scfr_cfg_t    cfg;
  scfr_result_t res;
  logic         in_vld_q;
  logic [7:0]   in_byte_q;
  logic         advance;
  logic         take;

  assign in_stall_o = in_vld_q && !advance;
  assign take       = in_valid_i && !in_stall_o;

  // Hold the input byte until the parser takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  scfr_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_vld_i    (in_vld_q),
    .in_byte_i   (in_byte_q),
    .advance_o   (advance),
    .res_vld_o   (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign checksum_ok_o    = res.checksum_ok;
  assign payload_length_o = res.payload_length;
  assign target_x_o       = res.target_x;
  assign target_y_o       = res.target_y;
  assign target_color_o   = res.target_color;
  assign target_shape_o   = res.target_shape;
  assign target_flag_o    = res.target_flag;

  // Stall only while a byte waits in the input register
  `SCFR_ASSERT_NOW(a_stall_needs_byte, in_stall_o, in_vld_q, "stall with empty input register")
  // Never step the parser over a blocked result
  `SCFR_ASSERT_NOW(a_no_step_on_block, out_valid_o && out_stall_i, !advance,
                   "parser stepped while result blocked")
  // A new result follows a parser step
  `SCFR_ASSERT_NEXT(a_result_from_step, !out_valid_o && !advance, !out_valid_o,
                    "result appeared without a parser step")

endmodule

// ===== hdl/scfr_cfg_regs.sv =====
// APB register bank holding the header values and the length limit.
module scfr_cfg_regs
  import scfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output scfr_cfg_t         cfg_o
);

  scfr_cfg_t  cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header  <= HEADER_RST;
      cfg_q.second_header <= HEADER_RST;
      cfg_q.length_limit  <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_FIRST_HEADER:  cfg_q.first_header  <= pwdata[7:0];
        REG_SECOND_HEADER: cfg_q.second_header <= pwdata[7:0];
        REG_LENGTH_LIMIT:  cfg_q.length_limit  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx)
      REG_FIRST_HEADER:  prdata = {{(DATA_W-8){1'b0}}, cfg_q.first_header};
      REG_SECOND_HEADER: prdata = {{(DATA_W-8){1'b0}}, cfg_q.second_header};
      REG_LENGTH_LIMIT:  prdata = {{(DATA_W-6){1'b0}}, cfg_q.length_limit};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/scfr_parser.sv =====
// Frame parser state, field buffer, held targets and result register.
module scfr_parser
  import scfr_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  scfr_cfg_t    cfg_i,
  input  logic         in_vld_i,
  input  logic [7:0]   in_byte_i,
  output logic         advance_o,
  output logic         res_vld_o,
  input  logic         res_stall_i,
  output scfr_result_t res_o
);

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_LENGTH  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CHECK   = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [5:0]  left_q, left_d;
  logic [5:0]  pidx_q, pidx_d;
  logic [5:0]  flen_q, flen_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  field_q [KEPT_BYTES];
  logic [7:0]  field_d [KEPT_BYTES];
  logic [15:0] x_q, x_d, y_q, y_d;
  logic [7:0]  color_q, color_d, shape_q, shape_d, flag_q, flag_d;
  logic        ok;
  logic        produce;
  logic        keep;
  logic        res_vld_q;
  scfr_result_t res_q;
  logic [7:0]  b;

  assign b = in_byte_i;

  // Move on when the result register is free or being drained
  assign advance_o = in_vld_i && (!res_vld_q || !res_stall_i);

  // Next state for one received byte
  always_comb begin
    phase_d = phase_q;
    left_d  = left_q;
    pidx_d  = pidx_q;
    flen_d  = flen_q;
    sum_d   = sum_q;
    x_d     = x_q;
    y_d     = y_q;
    color_d = color_q;
    shape_d = shape_q;
    flag_d  = flag_q;
    ok      = 1'b0;
    produce = 1'b0;
    keep    = 1'b0;
    priority if (phase_q == PH_HUNT && b == cfg_i.first_header) begin
      phase_d = PH_SECOND;
      sum_d   = b;
    end else if (phase_q == PH_SECOND && b == cfg_i.second_header) begin
      phase_d = PH_LENGTH;
      sum_d   = sum_q + b;
    end else if (phase_q == PH_LENGTH && b < {2'b00, cfg_i.length_limit}) begin
      phase_d = PH_PAYLOAD;
      flen_d  = b[5:0];
      left_d  = b[5:0];
      pidx_d  = '0;
      sum_d   = sum_q + b;
    end else if (phase_q == PH_PAYLOAD && left_q != '0) begin
      keep   = 1'b1;
      sum_d  = sum_q + b;
      left_d = left_q - 6'd1;
      pidx_d = pidx_q + 6'd1;
      if (left_q == 6'd1) begin
        phase_d = PH_CHECK;
      end
    end else if (phase_q == PH_CHECK) begin
      keep    = 1'b1;
      produce = 1'b1;
      ok      = (b == sum_q);
      phase_d = PH_HUNT;
      pidx_d  = '0;
    end else begin
      phase_d = PH_HUNT;
      pidx_d  = '0;
    end
    // Store the byte at the current payload position if it is kept
    for (int k = 0; k < KEPT_BYTES; k++) begin
      field_d[k] = (keep && pidx_q == 6'(k)) ? b : field_q[k];
    end
    // Take the target fields from the updated buffer on a match
    if (ok) begin
      x_d     = {field_d[0], field_d[1]};
      y_d     = {field_d[2], field_d[3]};
      color_d = field_d[4];
      shape_d = field_d[5];
      flag_d  = field_d[6];
    end
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      left_q  <= '0;
      pidx_q  <= '0;
      flen_q  <= '0;
      sum_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      color_q <= '0;
      shape_q <= '0;
      flag_q  <= '0;
      for (int k = 0; k < KEPT_BYTES; k++) begin
        field_q[k] <= '0;
      end
    end else if (advance_o) begin
      phase_q <= phase_d;
      left_q  <= left_d;
      pidx_q  <= pidx_d;
      flen_q  <= flen_d;
      sum_q   <= sum_d;
      x_q     <= x_d;
      y_q     <= y_d;
      color_q <= color_d;
      shape_q <= shape_d;
      flag_q  <= flag_d;
      for (int k = 0; k < KEPT_BYTES; k++) begin
        field_q[k] <= field_d[k];
      end
    end
  end

  // Result valid: set by a checksum byte, drop once transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance_o) begin
      res_vld_q <= produce;
    end else if (!res_stall_i) begin
      res_vld_q <= 1'b0;
    end
  end

  // Result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (advance_o && produce) begin
      res_q.checksum_ok    <= ok;
      res_q.payload_length <= flen_q;
      res_q.target_x       <= x_d;
      res_q.target_y       <= y_d;
      res_q.target_color   <= color_d;
      res_q.target_shape   <= shape_d;
      res_q.target_flag    <= flag_d;
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule
